@@ hw/rtl/bdac_pkg.sv @@
// Shared types, constants and the BCD digit correction for the decimal text converter.
package bdac_pkg;

   localparam int unsigned DIGIT_W = 4;
   localparam int unsigned CHAR_W = 6;
   localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

   // Occupancy of the queue between the conversion and emission parts.
   typedef struct packed {
      logic full;
      logic empty;
   } bdac_q_status_type;

   // Add-three correction applied to each BCD digit before a doubling shift.
   function automatic logic [DIGIT_W-1:0] dabble_digit(input logic [DIGIT_W-1:0] d);
      logic [DIGIT_W-1:0] r;
      if (d >= 4'd5) begin
         r = d + 4'd3;
      end else begin
         r = d;
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/bdac_front.sv @@
// Front part: accepts a number and converts it to BCD with shift-add-3 steps.
module bdac_front
   import bdac_pkg::*;
#(
   parameter int unsigned INPUT_WIDTH = 32,
   parameter int unsigned MAX_DIGITS  = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [INPUT_WIDTH-1:0]        req_value,
   input  bdac_q_status_type             q_status,
   output logic                          push,
   output logic [MAX_DIGITS*DIGIT_W-1:0] push_bcd,
   output logic                          push_ovf
);

   localparam int unsigned BCD_W = MAX_DIGITS * DIGIT_W;
   localparam int unsigned CNT_W = $clog2(INPUT_WIDTH + 1);

   typedef enum logic [2:0] {
      FE_IDLE = 3'b001,
      FE_CONV = 3'b010,
      FE_PUSH = 3'b100
   } fe_state_type;

   fe_state_type           state_ff, state_in;
   logic [INPUT_WIDTH-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]       bcd_ff, bcd_in;
   logic                   ovf_ff, ovf_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [BCD_W-1:0]       bcd_adj;

   always_comb begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
         bcd_adj[i*DIGIT_W +: DIGIT_W] = dabble_digit(bcd_ff[i*DIGIT_W +: DIGIT_W]);
      end
   end

   always_comb begin
      state_in = state_ff;
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      ovf_in   = ovf_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         FE_IDLE: begin
            if (start) begin
               bin_in   = req_value;
               bcd_in   = '0;
               ovf_in   = 1'b0;
               cnt_in   = CNT_W'(INPUT_WIDTH);
               state_in = FE_CONV;
            end
         end
         FE_CONV: begin
            // A bit shifted out of the top digit means the number has more digits than kept.
            bcd_in = {bcd_adj[BCD_W-2:0], bin_ff[INPUT_WIDTH-1]};
            ovf_in = ovf_ff | bcd_adj[BCD_W-1];
            bin_in = {bin_ff[INPUT_WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               state_in = FE_PUSH;
            end
         end
         FE_PUSH: begin
            if (!q_status.full) begin
               state_in = FE_IDLE;
            end
         end
         default: state_in = FE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FE_IDLE;
      end else begin
         state_ff <= state_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      ovf_ff <= ovf_in;
      cnt_ff <= cnt_in;
   end

   assign busy     = (state_ff != FE_IDLE);
   assign push     = (state_ff == FE_PUSH) && !q_status.full;
   assign push_bcd = bcd_ff;
   assign push_ovf = ovf_ff;

endmodule

@@ hw/rtl/bdac_queue.sv @@
// Two-entry queue of converted BCD words between the front and back parts.
module bdac_queue
   import bdac_pkg::*;
#(
   parameter int unsigned MAX_DIGITS = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic [MAX_DIGITS*DIGIT_W-1:0] push_bcd,
   input  logic                          push_ovf,
   input  logic                          pop,
   output logic [MAX_DIGITS*DIGIT_W-1:0] head_bcd,
   output logic                          head_ovf,
   output bdac_q_status_type             q_status
);

   localparam int unsigned BCD_W = MAX_DIGITS * DIGIT_W;

   logic [BCD_W-1:0] bcd_ff [2];
   logic [1:0]       ovf_ff;
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign q_status.full  = (count_ff == 2'd2);
   assign q_status.empty = (count_ff == 2'd0);
   assign do_push = push && !q_status.full;
   assign do_pop  = pop && !q_status.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         bcd_ff[wr_ptr_ff] <= push_bcd;
         ovf_ff[wr_ptr_ff] <= push_ovf;
      end
   end

   assign head_bcd = bcd_ff[rd_ptr_ff];
   assign head_ovf = ovf_ff[rd_ptr_ff];

endmodule

@@ hw/rtl/bdac_back.sv @@
// Back part: walks the BCD word from the top digit and emits ASCII characters.
module bdac_back
   import bdac_pkg::*;
#(
   parameter int unsigned MAX_DIGITS = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bdac_q_status_type             q_status,
   input  logic [MAX_DIGITS*DIGIT_W-1:0] head_bcd,
   input  logic                          head_ovf,
   output logic                          pop,
   output logic                          rsp_valid,
   output logic [CHAR_W-1:0]             rsp_digit_char,
   output logic                          rsp_last_digit
);

   localparam int unsigned BCD_W  = MAX_DIGITS * DIGIT_W;
   localparam int unsigned LEFT_W = $clog2(MAX_DIGITS + 1);

   logic               active_ff, active_in;
   logic [BCD_W-1:0]   bcd_ff, bcd_in;
   logic               started_ff, started_in;
   logic [LEFT_W-1:0]  left_ff, left_in;
   logic               valid_ff, valid_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic               last_ff, last_in;
   logic [DIGIT_W-1:0] top_digit;
   logic               is_last;

   assign top_digit = bcd_ff[BCD_W-1 -: DIGIT_W];
   assign is_last   = (left_ff == LEFT_W'(1));
   assign pop       = !active_ff && !q_status.empty;

   always_comb begin
      active_in  = active_ff;
      bcd_in     = bcd_ff;
      started_in = started_ff;
      left_in    = left_ff;
      valid_in   = 1'b0;
      char_in    = char_ff;
      last_in    = last_ff;
      if (active_ff) begin
         // Leading zeros are skipped unless the word was truncated or this is the last digit.
         if (is_last || started_ff || (top_digit != '0)) begin
            valid_in = 1'b1;
            char_in  = ASCII_ZERO + CHAR_W'(top_digit);
            last_in  = is_last;
         end
         started_in = started_ff | (top_digit != '0);
         bcd_in     = {bcd_ff[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
         left_in    = left_ff - 1'b1;
         if (is_last) begin
            active_in = 1'b0;
         end
      end else if (!q_status.empty) begin
         active_in  = 1'b1;
         bcd_in     = head_bcd;
         started_in = head_ovf;
         left_in    = LEFT_W'(MAX_DIGITS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         valid_ff  <= valid_in;
      end
      bcd_ff     <= bcd_in;
      started_ff <= started_in;
      left_ff    <= left_in;
      char_ff    <= char_in;
      last_ff    <= last_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_digit_char = char_ff;
   assign rsp_last_digit = last_ff;

endmodule

@@ hw/rtl/binary_to_decimal_ascii_core.sv @@
// Top level of the binary to decimal ASCII converter.
//
// A transaction is accepted at a rising clock edge where start is high and
// busy is low; req_value is taken then. The number is converted to BCD by
// INPUT_WIDTH shift-add-3 steps, one per cycle; busy stays high through
// them and the push of the result into the queue, and longer only when the
// two-entry queue toward the emission side is full. The emission side scans
// MAX_DIGITS digit positions from the top, one per cycle, skipping leading
// zeros. Busy goes low between numbers, and a new number is accepted
// only after the previous one has been pushed into the queue, while the
// emission side may still be sending earlier ones; results appear at
// most one per cycle. Each character is shown on rsp_digit_char
// for exactly one cycle with rsp_valid high, most significant digit first,
// and rsp_last_digit marks the final one. The receiver cannot stall the
// block, so it must take every strobed character. A zero input gives the
// single character '0'. When the number has more decimal digits than
// MAX_DIGITS, only the lowest MAX_DIGITS digits are sent, zeros included.
module binary_to_decimal_ascii_core
   import bdac_pkg::*;
#(
   parameter int unsigned INPUT_WIDTH = 32,
   parameter int unsigned MAX_DIGITS  = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [INPUT_WIDTH-1:0] req_value,
   output logic                   rsp_valid,
   output logic [CHAR_W-1:0]      rsp_digit_char,
   output logic                   rsp_last_digit
);

   localparam int unsigned BCD_W = MAX_DIGITS * DIGIT_W;

   bdac_q_status_type q_status;
   logic              push;
   logic [BCD_W-1:0]  push_bcd;
   logic              push_ovf;
   logic              pop;
   logic [BCD_W-1:0]  head_bcd;
   logic              head_ovf;

   // Conversion side: binary to BCD, keeping the lowest MAX_DIGITS digits.
   bdac_front #(
      .INPUT_WIDTH(INPUT_WIDTH),
      .MAX_DIGITS (MAX_DIGITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_value(req_value),
      .q_status (q_status),
      .push     (push),
      .push_bcd (push_bcd),
      .push_ovf (push_ovf)
   );

   // Decouples conversion from emission so each side stalls on its own.
   bdac_queue #(
      .MAX_DIGITS(MAX_DIGITS)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_bcd(push_bcd),
      .push_ovf(push_ovf),
      .pop     (pop),
      .head_bcd(head_bcd),
      .head_ovf(head_ovf),
      .q_status(q_status)
   );

   // Emission side: one digit position per cycle, characters registered.
   bdac_back #(
      .MAX_DIGITS(MAX_DIGITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_status      (q_status),
      .head_bcd      (head_bcd),
      .head_ovf      (head_ovf),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_digit_char(rsp_digit_char),
      .rsp_last_digit(rsp_last_digit)
   );

endmodule
